>>> hw/rtl/gic_pkg.sv
// gic_pkg: shared types, sizes and register codes of the gamepad input conditioner
package gic_pkg;

    // sizes
    localparam int SWITCHES       = 4;
    localparam int DEBOUNCE_DEPTH = 3;
    localparam int ADC_BITS       = 12;
    localparam int NUM_REGS       = 8;
    localparam int NUM_EDGES      = SWITCHES + 7;
    localparam int RING_BITS      = (DEBOUNCE_DEPTH > 1) ? $clog2(DEBOUNCE_DEPTH) : 1;
    localparam int REG_IDX_BITS   = $clog2(NUM_REGS);

    // request codes
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_EVAL   = 1'b1;

    // configuration register indexes
    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_STICK_HIGH   = 3'd0,
        REG_STICK_LOW    = 3'd1,
        REG_NEUTRAL_HIGH = 3'd2,
        REG_NEUTRAL_LOW  = 3'd3,
        REG_LEVER_PUSH   = 3'd4,
        REG_LEVER_LEFT   = 3'd5,
        REG_LEVER_MID    = 3'd6,
        REG_LEVER_RIGHT  = 3'd7
    } reg_index_t;

    // reset values of the limit registers, in index order
    localparam logic [ADC_BITS-1:0] CFG_RESET [NUM_REGS] = '{
        ADC_BITS'(3277), ADC_BITS'(819), ADC_BITS'(2662), ADC_BITS'(1434),
        ADC_BITS'(614), ADC_BITS'(819), ADC_BITS'(2048), ADC_BITS'(2867)
    };

    // edge machine state, also the 2-bit code on the outputs
    typedef enum logic [1:0] {
        EDGE_OFF     = 2'd0,
        EDGE_PUSH    = 2'd1,
        EDGE_ON      = 2'd2,
        EDGE_RELEASE = 2'd3
    } edge_state_t;

    // one result item
    typedef struct packed {
        logic [2*SWITCHES-1:0] switch_states;
        logic [7:0]            stick_states;
        logic [5:0]            lever_states;
    } result_t;

endpackage

>>> hw/rtl/gic_core.sv
// gic_core: debounce ring, stick and lever decode, edge machines and limit registers
module gic_core
    import gic_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [REG_IDX_BITS-1:0] cfg_index,
    input  logic [ADC_BITS-1:0]     cfg_data,
    input  logic                    accept,
    input  logic                    req_type,
    input  logic [SWITCHES-1:0]     switch_pins,
    input  logic [ADC_BITS-1:0]     stick_horizontal,
    input  logic [ADC_BITS-1:0]     stick_vertical,
    input  logic [ADC_BITS-1:0]     lever_level,
    output logic                    res_valid,
    output result_t                 result
);

    logic [ADC_BITS-1:0]  cfg_reg [NUM_REGS];
    logic [SWITCHES-1:0]  ring_reg [DEBOUNCE_DEPTH];
    logic [RING_BITS-1:0] ring_pos_reg;
    logic [RING_BITS-1:0] ring_pos_next;
    edge_state_t          edge_reg [NUM_EDGES];
    edge_state_t          edge_next [NUM_EDGES];
    logic [NUM_EDGES-1:0] held;
    logic [NUM_EDGES-1:0] level;
    logic [SWITCHES-1:0]  sw_level;
    logic [3:0]           stick_level;
    logic [2:0]           lever_bits;
    logic                 sample_acc;
    logic                 eval_acc;

    assign sample_acc = accept && (req_type == REQ_SAMPLE);
    assign eval_acc   = accept && (req_type == REQ_EVAL);
    assign res_valid  = eval_acc;

    // limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_REGS; r++)
            begin
                cfg_reg[r] <= CFG_RESET[r];
            end
        end
        else if (cfg_write)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // ring position wraps after the last entry
    always_comb
    begin
        if (ring_pos_reg == RING_BITS'(DEBOUNCE_DEPTH - 1))
        begin
            ring_pos_next = '0;
        end
        else
        begin
            ring_pos_next = ring_pos_reg + RING_BITS'(1);
        end
    end

    // sample ring, all switches inactive after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < DEBOUNCE_DEPTH; d++)
            begin
                ring_reg[d] <= '1;
            end
            ring_pos_reg <= '0;
        end
        else if (sample_acc)
        begin
            ring_reg[ring_pos_reg] <= switch_pins;
            ring_pos_reg           <= ring_pos_next;
        end
    end

    // held level of every edge machine
    always_comb
    begin
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            held[e] = (edge_reg[e] == EDGE_PUSH) || (edge_reg[e] == EDGE_ON);
        end
    end

    // switch debounce: pressed or released only when all samples agree
    always_comb
    begin
        logic all_low;
        logic all_high;
        for (int i = 0; i < SWITCHES; i++)
        begin
            all_low  = 1'b1;
            all_high = 1'b1;
            for (int d = 0; d < DEBOUNCE_DEPTH; d++)
            begin
                all_low  = all_low && !ring_reg[d][i];
                all_high = all_high && ring_reg[d][i];
            end
            if (all_low)
            begin
                sw_level[i] = 1'b1;
            end
            else if (all_high)
            begin
                sw_level[i] = 1'b0;
            end
            else
            begin
                sw_level[i] = held[i];
            end
        end
    end

    // stick axes: outer limits, neutral band, otherwise hold
    always_comb
    begin
        logic [ADC_BITS-1:0] axis;
        for (int a = 0; a < 2; a++)
        begin
            axis = (a == 0) ? stick_horizontal : stick_vertical;
            if (axis > cfg_reg[REG_STICK_HIGH])
            begin
                stick_level[2*a]     = 1'b0;
                stick_level[2*a + 1] = 1'b1;
            end
            else if (axis < cfg_reg[REG_STICK_LOW])
            begin
                stick_level[2*a]     = 1'b1;
                stick_level[2*a + 1] = 1'b0;
            end
            else if (axis < cfg_reg[REG_NEUTRAL_HIGH] && axis > cfg_reg[REG_NEUTRAL_LOW])
            begin
                stick_level[2*a]     = 1'b0;
                stick_level[2*a + 1] = 1'b0;
            end
            else
            begin
                stick_level[2*a]     = held[SWITCHES + 2*a];
                stick_level[2*a + 1] = held[SWITCHES + 2*a + 1];
            end
        end
    end

    // lever windows: push, left, right, none
    always_comb
    begin
        lever_bits = 3'b000;
        if (lever_level < cfg_reg[REG_LEVER_PUSH])
        begin
            lever_bits[0] = 1'b1;
        end
        else if (lever_level > cfg_reg[REG_LEVER_LEFT] &&
                 lever_level < cfg_reg[REG_LEVER_MID])
        begin
            lever_bits[1] = 1'b1;
        end
        else if (lever_level > cfg_reg[REG_LEVER_MID] &&
                 lever_level < cfg_reg[REG_LEVER_RIGHT])
        begin
            lever_bits[2] = 1'b1;
        end
    end

    // all levels in edge machine order
    assign level = {lever_bits, stick_level, sw_level};

    // edge machine step
    always_comb
    begin
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            if (held[e])
            begin
                edge_next[e] = level[e] ? EDGE_ON : EDGE_RELEASE;
            end
            else
            begin
                edge_next[e] = level[e] ? EDGE_PUSH : EDGE_OFF;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                edge_reg[e] <= EDGE_OFF;
            end
        end
        else if (eval_acc)
        begin
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                edge_reg[e] <= edge_next[e];
            end
        end
    end

    // pack the new states into one result
    always_comb
    begin
        for (int i = 0; i < SWITCHES; i++)
        begin
            result.switch_states[2*i +: 2] = edge_next[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            result.stick_states[2*i +: 2] = edge_next[SWITCHES + i];
        end
        for (int i = 0; i < 3; i++)
        begin
            result.lever_states[2*i +: 2] = edge_next[SWITCHES + 4 + i];
        end
    end

endmodule

>>> hw/rtl/gamepad_input_conditioner.sv
// gamepad_input_conditioner: top level with output register and skid stage
//
// channel | direction | handshake            | payload
// in      | to block  | in_valid / in_stall  | req_type, switch_pins, stick_*, lever_level
// out     | from block| out_valid / out_stall| switch_states, stick_states, lever_states
// cfg     | to block  | cfg_write            | cfg_index, cfg_data
//
// One item per cycle while in_stall is low: all decode and edge logic sits between the
// state registers and the output register; a held output sends the result to the skid.
// A sample item updates the debounce ring and gives no result.
// Reset (rst_n low) restores limit registers, fills the ring with inactive samples and
// clears all edge machines to off.
// A held result parks in a two-entry output (register plus skid); in_stall rises only
// when both are full.
module gamepad_input_conditioner
    import gic_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [REG_IDX_BITS-1:0] cfg_index,
    input  logic [ADC_BITS-1:0]     cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    req_type,
    input  logic [SWITCHES-1:0]     switch_pins,
    input  logic [ADC_BITS-1:0]     stick_horizontal,
    input  logic [ADC_BITS-1:0]     stick_vertical,
    input  logic [ADC_BITS-1:0]     lever_level,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [2*SWITCHES-1:0]   switch_states,
    output logic [7:0]              stick_states,
    output logic [5:0]              lever_states
);

    logic    accept;
    logic    res_valid;
    result_t result;
    logic    out_free;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    result_t skid_data_next;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !in_stall;

    gic_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .accept           (accept),
        .req_type         (req_type),
        .switch_pins      (switch_pins),
        .stick_horizontal (stick_horizontal),
        .stick_vertical   (stick_vertical),
        .lever_level      (lever_level),
        .res_valid        (res_valid),
        .result           (result)
    );

    // output register and skid stage
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (res_valid)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end
        else if (out_free)
        begin
            out_valid_next  = skid_valid_reg;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid     = out_valid_reg;
    assign switch_states = out_data_reg.switch_states;
    assign stick_states  = out_data_reg.stick_states;
    assign lever_states  = out_data_reg.lever_states;

endmodule

>>> hw/rtl/gic_checker.sv
// gic_assert: port-level assertions for the gamepad input conditioner, with bind
module gic_assert
    import gic_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  req_type,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [2*SWITCHES-1:0] switch_states,
    input logic [7:0]            stick_states,
    input logic [5:0]            lever_states
);

    // a stalled item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(switch_states) &&
        $stable(stick_states) && $stable(lever_states))
        else $error("stalled output item changed");

    // an accepted evaluate item always shows up next cycle or is queued behind one
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && req_type == REQ_EVAL |=> out_valid)
        else $error("evaluate item produced no result");

    // a sample item into an empty output makes no result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && req_type == REQ_SAMPLE && !out_valid |=> !out_valid)
        else $error("sample item produced a result");

    // input back-pressure only when a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

endmodule

bind gamepad_input_conditioner gic_assert u_gic_assert (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .switch_states (switch_states),
    .stick_states  (stick_states),
    .lever_states  (lever_states)
);
